/* sv/ssa_pkg.sv */
package ssa_pkg;

  localparam int unsigned KIND_W   = 1;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOSLAB = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NULL   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD    = 2'd3;

  localparam logic [1:0] TAG_EMPTY   = 2'd0;
  localparam logic [1:0] TAG_PARTIAL = 2'd1;
  localparam logic [1:0] TAG_FULL    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_ITEM_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ITEM_COUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLAB_SHIFT   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd3;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [ADDR_W-1:0] address;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   result_address;
  } rsp_t;

endpackage

/* sv/ssa_if.sv */
interface ssa_req_if;
  logic              valid;
  logic              ready;
  ssa_pkg::req_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ssa_rsp_if;
  logic              valid;
  logic              ready;
  ssa_pkg::rsp_t     payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/ssa_div.sv */
// Restoring divider, one quotient bit per cycle: offset / item_size.
module ssa_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [19:0] dividend,
  input  logic [12:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [19:0] quotient,
  output logic [12:0] remainder
);
  import ssa_pkg::*;

  logic [19:0] q_r, q_nxt;
  logic [12:0] rem_r, rem_nxt;
  logic [12:0] dvs_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic [13:0] trial;

  // one shift-subtract step
  always_comb begin
    trial   = {rem_r, q_r[19]} - {1'b0, dvs_r};
    q_nxt   = {q_r[18:0], ~trial[13]};
    rem_nxt = trial[13] ? {rem_r[11:0], q_r[19]} : trial[12:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'd0;
        q_r    <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        q_r   <= q_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd19) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = q_r;
  assign remainder = rem_r;
endmodule

/* sv/slab_slot_allocator_unit.sv */
// channel | dir | handshake     | payload
// in_     | in  | valid/ready   | kind, address
// out_    | out | valid/ready   | status, result_address
// cfg_    | in  | we (no ready) | index, data
// Alloc: the bitmap of a partial slab is scanned one bit a cycle; an empty slab needs no scan.
// Out of slabs, null or out-of-range frees skip the divider and the list updates.
// Free: the bit-serial divider finds the slot, then come the checks and list updates.
// The next request is accepted only after the result is loaded; a full result register stalls the sequencer.
// Reset (rst_n, synchronous) puts every slab on the empty list; no clearing pass.
module slab_slot_allocator_unit #(
  parameter int unsigned NUM_SLABS = 16,
  parameter int unsigned MAX_SLOTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  ssa_req_if.sink                    in_ch,
  ssa_rsp_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [ssa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [ssa_pkg::CFG_W-1:0]  cfg_data
);
  import ssa_pkg::*;

  localparam int unsigned SW = $clog2(NUM_SLABS + 1);
  localparam int unsigned IW = $clog2(NUM_SLABS);
  localparam int unsigned BW = $clog2(MAX_SLOTS);
  localparam logic [SW-1:0] NIL = SW'(NUM_SLABS);

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_ALLOC_UPD, S_DIV, S_FCHECK, S_UNLINK, S_PUSH, S_RESP
  } state_t;

  state_t state_r;

  // configuration
  logic [12:0] item_size_r;
  logic [6:0]  item_count_r;
  logic [4:0]  slab_shift_r;
  logic [7:0]  header_r;

  logic [12:0] eff_size;
  logic [6:0]  eff_count;
  logic [4:0]  eff_shift;
  logic [7:0]  eff_hdr;
  logic [MAX_SLOTS-1:0] emask;

  always_comb begin
    eff_size = (item_size_r == '0) ? 13'd1 : item_size_r;
    eff_hdr  = (header_r == '0) ? 8'd1 : header_r;
    if (item_count_r < 7'd2) eff_count = 7'd2;
    else if (item_count_r > 7'(MAX_SLOTS)) eff_count = 7'(MAX_SLOTS);
    else eff_count = item_count_r;
    if (slab_shift_r < 5'd6) eff_shift = 5'd6;
    else if (slab_shift_r > 5'd20) eff_shift = 5'd20;
    else eff_shift = slab_shift_r;
    for (int i = 0; i < MAX_SLOTS; i++) emask[i] = (7'(i) < eff_count);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_size_r  <= 13'd1;
      item_count_r <= 7'd24;
      slab_shift_r <= 5'd6;
      header_r     <= 8'd40;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ITEM_SIZE:    item_size_r  <= cfg_data;
        REG_ITEM_COUNT:   item_count_r <= cfg_data[6:0];
        REG_SLAB_SHIFT:   slab_shift_r <= cfg_data[4:0];
        REG_HEADER_BYTES: header_r     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // slab state: link/tag per slab, heads
  logic [MAX_SLOTS-1:0] mask_r [NUM_SLABS];
  logic [1:0]           tag_r  [NUM_SLABS];
  logic [SW-1:0]        next_r [NUM_SLABS];
  logic [SW-1:0]        prev_r [NUM_SLABS];
  logic [SW-1:0]        head_r [3];

  // working registers
  logic [IW-1:0]        cur_r;
  logic [MAX_SLOTS-1:0] m_r;
  logic [BW-1:0]        slot_r;
  logic [1:0]           dest_r;
  logic                 move_r;
  logic [ADDR_W-1:0]    addr_r;
  rsp_t                 rsp_r;
  rsp_t                 out_rsp_r;
  logic                 out_valid_r;

  // address adder: base + header + slot * size
  logic [ADDR_W-1:0] slot_addr;
  logic [19:0]       slot_prod;
  assign slot_prod = 20'(slot_r) * 20'(eff_size);
  assign slot_addr = (ADDR_W'(cur_r) << eff_shift) + ADDR_W'(eff_hdr) + ADDR_W'(slot_prod);

  // free decode
  logic [ADDR_W-1:0] sidx;
  logic [19:0]       off;
  logic [19:0]       rel;
  logic              free_range_bad;
  assign sidx = addr_r >> eff_shift;
  assign off  = 20'(addr_r & ((ADDR_W'(1) << eff_shift) - ADDR_W'(1)));
  assign rel  = off - 20'(eff_hdr);
  assign free_range_bad = (sidx >= ADDR_W'(NUM_SLABS)) || (off < 20'(eff_hdr));

  logic        div_start;
  logic        div_busy;
  logic        div_done;
  logic [19:0] quo;
  logic [12:0] rem;

  ssa_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(rel), .divisor(eff_size),
    .busy(div_busy), .done(div_done), .quotient(quo), .remainder(rem)
  );

  // one divider run per free whose address passed the range checks
  assign div_start = (state_r == S_DIV) && !free_range_bad && !div_busy && !div_done;

  logic [SW-1:0] pn, nn;
  logic [SW-1:0] hd;
  assign pn = prev_r[cur_r];
  assign nn = next_r[cur_r];
  assign hd = head_r[dest_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      move_r      <= 1'b0;
      for (int i = 0; i < NUM_SLABS; i++) begin
        mask_r[i] <= '0;
        tag_r[i]  <= TAG_EMPTY;
        next_r[i] <= (i + 1 < NUM_SLABS) ? SW'(i + 1) : NIL;
        prev_r[i] <= (i == 0) ? NIL : SW'(i - 1);
      end
      head_r[TAG_EMPTY]   <= '0;
      head_r[TAG_PARTIAL] <= NIL;
      head_r[TAG_FULL]    <= NIL;
    end else begin
      // result register: load from the sequencer, clear once taken
      if (state_r == S_RESP && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
        out_rsp_r   <= rsp_r;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            addr_r <= in_ch.payload.address;
            rsp_r  <= '{status: ST_OK, result_address: '0};
            move_r <= 1'b0;
            if (in_ch.payload.kind == KIND_ALLOC) begin
              if (head_r[TAG_PARTIAL] != NIL) begin
                cur_r  <= IW'(head_r[TAG_PARTIAL]);
                m_r    <= mask_r[IW'(head_r[TAG_PARTIAL])];
                slot_r <= '0;
                state_r <= S_SCAN;
              end else if (head_r[TAG_EMPTY] != NIL) begin
                cur_r  <= IW'(head_r[TAG_EMPTY]);
                slot_r <= '0;
                m_r    <= emask ^ MAX_SLOTS'(1);
                dest_r <= TAG_PARTIAL;
                move_r <= 1'b1;
                state_r <= S_ALLOC_UPD;
              end else begin
                rsp_r.status <= ST_NOSLAB;
                state_r <= S_RESP;
              end
            end else if (in_ch.payload.address == '0) begin
              rsp_r.status <= ST_NULL;
              state_r <= S_RESP;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        // walk the bitmap one bit per cycle
        S_SCAN: begin
          if (m_r[slot_r] || slot_r == BW'(MAX_SLOTS - 1)) begin
            m_r[slot_r] <= 1'b0;
            if ((m_r & ~(MAX_SLOTS'(1) << slot_r)) == '0) begin
              dest_r <= TAG_FULL;
              move_r <= 1'b1;
            end
            state_r <= S_ALLOC_UPD;
          end else begin
            slot_r <= slot_r + BW'(1);
          end
        end
        S_ALLOC_UPD: begin
          mask_r[cur_r] <= m_r;
          rsp_r.result_address <= slot_addr;
          state_r <= move_r ? S_UNLINK : S_RESP;
        end
        // range checks first, then wait for the divider
        S_DIV: begin
          if (free_range_bad) begin
            rsp_r.status <= ST_BAD;
            state_r <= S_RESP;
          end else begin
            cur_r <= IW'(sidx);
            if (div_done) state_r <= S_FCHECK;
          end
        end
        S_FCHECK: begin
          if (rem != '0 || quo >= 20'(eff_count) ||
              (tag_r[cur_r] != TAG_PARTIAL && tag_r[cur_r] != TAG_FULL) ||
              mask_r[cur_r][BW'(quo)]) begin
            rsp_r.status <= ST_BAD;
            state_r <= S_RESP;
          end else begin
            slot_r <= BW'(quo);
            if (tag_r[cur_r] == TAG_FULL) begin
              mask_r[cur_r][BW'(quo)] <= 1'b1;
              dest_r <= TAG_PARTIAL;
              state_r <= S_UNLINK;
            end else if (((mask_r[cur_r] | (MAX_SLOTS'(1) << quo[BW-1:0])) & emask) == emask) begin
              mask_r[cur_r] <= emask;
              dest_r <= TAG_EMPTY;
              state_r <= S_UNLINK;
            end else begin
              mask_r[cur_r][BW'(quo)] <= 1'b1;
              state_r <= S_RESP;
            end
          end
        end
        S_UNLINK: begin
          if (pn != NIL) next_r[IW'(pn)] <= nn;
          else head_r[tag_r[cur_r]] <= nn;
          if (nn != NIL) prev_r[IW'(nn)] <= pn;
          state_r <= S_PUSH;
        end
        S_PUSH: begin
          next_r[cur_r] <= hd;
          prev_r[cur_r] <= NIL;
          if (hd != NIL) prev_r[IW'(hd)] <= SW'(cur_r);
          head_r[dest_r] <= SW'(cur_r);
          tag_r[cur_r] <= dest_r;
          state_r <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_r || out_ch.ready) begin
            move_r <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready    = (state_r == S_IDLE);
  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_rsp_r;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_alloc_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload.status != ST_OK) |-> out_ch.payload.result_address == '0)
    else $error("address on failed result");
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> $past(div_busy)) else $error("divider done without run");
`endif
endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ssa_pkg::*;

  localparam int NSLAB = 16;
  localparam logic [4:0] NIL = 5'd16;
  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  ssa_req_if in_ch ();
  ssa_rsp_if out_ch ();

  slab_slot_allocator_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // allocator shadow state
  logic [63:0] slot_free[NSLAB];
  logic [1:0] slab_list[NSLAB];
  logic [4:0] link_nxt[NSLAB];
  logic [4:0] link_prv[NSLAB];
  logic [4:0] partial_hd, empty_hd, full_hd;
  logic [12:0] r_size;
  logic [6:0] r_count;
  logic [4:0] r_shift;
  logic [7:0] r_hdr;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic [31:0] live_addrs[$];
  logic [31:0] freed_addrs[$];
  int mismatches = 0;
  int cycles = 0;
  bit tx_quiet = 0;
  bit rx_quiet = 0;
  int tx_gap = 0;
  int rx_stall = 0;

  // effective register values after saturation
  function automatic logic [63:0] eff_size();
    return (r_size == 0) ? 64'd1 : 64'(r_size);
  endfunction
  function automatic logic [63:0] eff_hdr();
    return (r_hdr == 0) ? 64'd1 : 64'(r_hdr);
  endfunction
  function automatic logic [63:0] eff_count();
    if (r_count < 2) return 64'd2;
    if (r_count > 64) return 64'd64;
    return 64'(r_count);
  endfunction
  function automatic int eff_shift();
    if (r_shift < 6) return 6;
    if (r_shift > 20) return 20;
    return int'(r_shift);
  endfunction
  function automatic logic [63:0] full_pattern();
    logic [63:0] c;
    c = eff_count();
    return (c >= 64) ? '1 : ((64'd1 << c) - 64'd1);
  endfunction
  function automatic logic [31:0] slot_address(int s, logic [63:0] slot);
    logic [63:0] a;
    a = (64'(s) << eff_shift()) + eff_hdr() + slot * eff_size();
    return a[31:0];
  endfunction

  // list bookkeeping
  function automatic logic [4:0] list_head(logic [1:0] tag);
    if (tag == TAG_PARTIAL) return partial_hd;
    if (tag == TAG_FULL) return full_hd;
    return empty_hd;
  endfunction
  function automatic void set_head(logic [1:0] tag, logic [4:0] v);
    if (tag == TAG_PARTIAL) partial_hd = v;
    else if (tag == TAG_FULL) full_hd = v;
    else empty_hd = v;
  endfunction
  function automatic void unlink(int s);
    logic [4:0] p, n;
    p = link_prv[s];
    n = link_nxt[s];
    if (p < NIL) link_nxt[p] = n;
    else set_head(slab_list[s], n);
    if (n < NIL) link_prv[n] = p;
    link_nxt[s] = NIL;
    link_prv[s] = NIL;
  endfunction
  function automatic void push_front(int s, logic [1:0] tag);
    logic [4:0] h;
    h = list_head(tag);
    link_nxt[s] = h;
    link_prv[s] = NIL;
    if (h < NIL) link_prv[h] = 5'(s);
    set_head(tag, 5'(s));
    slab_list[s] = tag;
  endfunction

  // response expected for one request, updates shadow state
  function automatic rsp_t allocator_response(req_t r);
    rsp_t o;
    int s;
    logic [63:0] m, slot, off, rel, bit_m, nm;
    o.status = ST_OK;
    o.result_address = '0;
    if (r.kind == KIND_ALLOC) begin
      if (partial_hd < NIL) begin
        s = partial_hd;
        m = slot_free[s];
        slot = 0;
        while (slot < 63 && m[slot] == 1'b0) slot++;
        m[slot] = 1'b0;
        slot_free[s] = m;
        if (m == 0) begin
          unlink(s);
          push_front(s, TAG_FULL);
        end
        o.result_address = slot_address(s, slot);
      end else if (empty_hd < NIL) begin
        s = empty_hd;
        unlink(s);
        slot_free[s] = full_pattern() ^ 64'd1;
        push_front(s, TAG_PARTIAL);
        o.result_address = slot_address(s, 0);
      end else begin
        o.status = ST_NOSLAB;
      end
      return o;
    end
    if (r.address == 0) begin
      o.status = ST_NULL;
      return o;
    end
    o.status = ST_BAD;
    if ((64'(r.address) >> eff_shift()) >= NSLAB) return o;
    s = int'(64'(r.address) >> eff_shift());
    off = 64'(r.address) & ((64'd1 << eff_shift()) - 64'd1);
    if (off < eff_hdr()) return o;
    rel = off - eff_hdr();
    if (rel % eff_size() != 0) return o;
    slot = rel / eff_size();
    if (slot >= eff_count()) return o;
    if (slab_list[s] != TAG_PARTIAL && slab_list[s] != TAG_FULL) return o;
    bit_m = 64'd1 << slot;
    if ((slot_free[s] & bit_m) != 0) return o;
    o.status = ST_OK;
    nm = slot_free[s] | bit_m;
    if (slab_list[s] == TAG_FULL) begin
      slot_free[s] = nm;
      unlink(s);
      push_front(s, TAG_PARTIAL);
    end else if ((nm & full_pattern()) == full_pattern()) begin
      slot_free[s] = full_pattern();
      unlink(s);
      push_front(s, TAG_EMPTY);
    end else begin
      slot_free[s] = nm;
    end
    return o;
  endfunction

  // track addresses in use so random frees hit real slots
  function automatic void note_result(req_t r, rsp_t o);
    int idx[$];
    if (r.kind == KIND_ALLOC && o.status == ST_OK) begin
      live_addrs.push_back(o.result_address);
    end else if (r.kind == KIND_FREE && o.status == ST_OK) begin
      idx = live_addrs.find_first_index(x) with (x == r.address);
      if (idx.size() > 0) live_addrs.delete(idx[0]);
      freed_addrs.push_back(r.address);
      if (freed_addrs.size() > 8) void'(freed_addrs.pop_front());
    end
  endfunction

  // clock, shadow reset
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < NSLAB; i++) begin
      slot_free[i] = '0;
      slab_list[i] = TAG_EMPTY;
      link_nxt[i] = (i + 1 < NSLAB) ? 5'(i + 1) : NIL;
      link_prv[i] = (i == 0) ? NIL : 5'(i - 1);
    end
    partial_hd = NIL;
    empty_hd = 5'd0;
    full_hd = NIL;
    r_size = 13'd1;
    r_count = 7'd24;
    r_shift = 5'd6;
    r_hdr = 8'd40;
  end

  // request driver
  always @(posedge clk) begin
    int g;
    rsp_t o;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else begin
      g = tx_gap;
      if (in_ch.valid && in_ch.ready) begin
        o = allocator_response(in_ch.payload);
        expected_rsps.push_back(o);
        note_result(in_ch.payload, o);
        g = tx_quiet ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 60) == 0) tx_quiet = ~tx_quiet;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (g > 0) begin
          in_ch.valid <= 1'b0;
          g--;
        end else if (pending_reqs.size() > 0) begin
          in_ch.payload <= pending_reqs.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      tx_gap <= g;
    end
  end

  // response monitor and checker
  always @(posedge clk) begin
    int st;
    rsp_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_stall <= 0;
    end else begin
      st = rx_stall;
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rsps.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d addr %h",
                     out_ch.payload.status, out_ch.payload.result_address);
        end else begin
          e = expected_rsps.pop_front();
          if (out_ch.payload.status !== e.status ||
              out_ch.payload.result_address !== e.result_address) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp status %0d addr %h, got status %0d addr %h",
                       e.status, e.result_address,
                       out_ch.payload.status, out_ch.payload.result_address);
          end
        end
        st = rx_quiet ? 0 : $urandom_range(0, 6);
        if ($urandom_range(0, 50) == 0) rx_quiet = ~rx_quiet;
      end
      if (st == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b0;
        st--;
      end
      rx_stall <= st;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(logic kind, logic [31:0] addr);
    req_t r;
    r.kind = kind;
    r.address = addr;
    while (pending_reqs.size() > 0) @(negedge clk);
    pending_reqs.push_back(r);
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_reqs.size() > 0 || in_ch.valid || expected_rsps.size() > 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_ITEM_SIZE: r_size = val[12:0];
      REG_ITEM_COUNT: r_count = val[6:0];
      REG_SLAB_SHIFT: r_shift = val[4:0];
      default: r_hdr = val[7:0];
    endcase
  endtask

  task automatic configure(logic [CFG_W-1:0] sz, logic [CFG_W-1:0] cnt,
                           logic [CFG_W-1:0] sh, logic [CFG_W-1:0] hdr);
    drain();
    repeat (8) @(posedge clk);
    write_reg(REG_ITEM_SIZE, sz);
    write_reg(REG_ITEM_COUNT, cnt);
    write_reg(REG_SLAB_SHIFT, sh);
    write_reg(REG_HEADER_BYTES, hdr);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // a handful of hand-picked cases under the current settings
  task automatic directed_cases();
    logic [31:0] a, base15;
    base15 = 32'(64'(15) << eff_shift());
    send(KIND_FREE, 32'd0);
    send(KIND_FREE, base15 + 32'(eff_hdr()));
    send(KIND_ALLOC, 32'd0);
    send(KIND_ALLOC, 32'd0);
    drain();
    a = live_addrs[$];
    send(KIND_FREE, a);
    send(KIND_FREE, a);
    send(KIND_FREE, a + 32'd1);
    send(KIND_FREE, 32'(eff_hdr()) - 32'd1);
    send(KIND_FREE, 32'(eff_hdr() + eff_count() * eff_size()));
    send(KIND_FREE, 32'(64'(NSLAB) << eff_shift()));
    send(KIND_FREE, 32'hFFFF_FFFF);
  endtask

  task automatic random_items(int n, int alloc_pct);
    int pick;
    logic [31:0] a;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < alloc_pct) begin
        send(KIND_ALLOC, $urandom());
      end else if (pick < 90 && live_addrs.size() > 0) begin
        send(KIND_FREE, live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
      end else begin
        case ($urandom_range(0, 4))
          0: a = 32'd0;
          1: a = $urandom();
          2: a = (freed_addrs.size() > 0) ?
                 freed_addrs[$urandom_range(0, freed_addrs.size() - 1)] : $urandom();
          3: a = slot_address(int'($urandom_range(0, NSLAB - 1)), eff_count());
          default: a = 32'(64'($urandom_range(NSLAB, NSLAB + 3)) << eff_shift())
                       + 32'(eff_hdr());
        endcase
        send(KIND_FREE, a);
      end
    end
  endtask

  // stimulus sequence
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_ITEM_SIZE;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    directed_cases();
    random_items(150, 55);

    // smallest slabs: run out of slabs, then directed and random cases
    configure(13'd0, 13'd1, 13'd0, 13'd0);
    for (int i = 0; i < 34; i++) send(KIND_ALLOC, 32'd0);
    drain();
    directed_cases();
    random_items(200, 45);

    configure(13'd4096, 13'd64, 13'd20, 13'd255);
    directed_cases();
    random_items(200, 60);

    configure(13'h1FFF, 13'h7F, 13'h1F, 13'hFF);
    random_items(150, 55);

    configure(13'd3, 13'd5, 13'd8, 13'd12);
    directed_cases();
    random_items(100, 60);
    drain();
    random_items(150, 50);

    for (int p = 0; p < 4; p++) begin
      configure(13'($urandom_range(1, 64)), 13'($urandom_range(2, 12)),
                13'($urandom_range(6, 14)), 13'($urandom_range(1, 255)));
      random_items(180, int'($urandom_range(45, 65)));
    end

    drain();
    repeat (150) @(posedge clk);
    if (mismatches == 0 && expected_rsps.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/ssa_pkg.sv
sv/ssa_if.sv
sv/ssa_div.sv
sv/slab_slot_allocator_unit.sv
dv/tb_top.sv
